FILE: hdl/reed_solomon_check_encoder_top_assert.svh
// assertion macros for the reed-solomon check encoder
// used by the controller; empty bodies when SYNTH is defined
`ifndef REED_SOLOMON_CHECK_ENCODER_TOP_ASSERT_SVH
`define REED_SOLOMON_CHECK_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define RSCE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RSCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RSCE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define RSCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/rsce_pkg.sv
// shared types, constants and field arithmetic for the reed-solomon check encoder
// no dependencies
`timescale 1ns / 1ps
package rsce_pkg;
	localparam int SYM_W         = 12;
	localparam int MAX_CHECK_DEF = 32;
	localparam int FB_W          = 4;
	localparam int POLY_W        = 13;
	localparam int NC_W          = 6;
	localparam int NCX_W         = NC_W + 1;
	localparam int M_W           = $clog2(SYM_W + 1);
	localparam int RED_N         = 2 * SYM_W - 1;
	localparam int RED_W         = $clog2(RED_N);
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = POLY_W;

	localparam logic [FB_W-1:0]   FB_RST   = FB_W'(6);
	localparam logic [POLY_W-1:0] POLY_RST = POLY_W'(67);
	localparam logic [NC_W-1:0]   NC_RST   = NC_W'(5);

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [RED_N-1:0][SYM_W-1:0] red_tab_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_BITS  = 2'd0,
		REG_FIELD_POLY  = 2'd1,
		REG_CHECK_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             red_step;
		logic [RED_W-1:0] red_idx;
		logic             gen_init;
		logic             gen_step;
		logic             take;
		logic             emit;
		logic             emit_last;
	} rsce_cmd_t;

	typedef struct packed {
		logic            cfg_wr;
		logic [NC_W-1:0] nc_eff;
	} rsce_sts_t;

	// multiply by x, reduced by the masked polynomial
	function automatic sym_t gf_mulx(sym_t a, sym_t msb, sym_t poly_m, sym_t mask);
		return ((a << 1) & mask) ^ (((a & msb) != '0) ? poly_m : '0);
	endfunction

	// carry-less product, then reduction through the table of x^s
	function automatic sym_t gf_mul(sym_t a, sym_t b, red_tab_t red);
		logic [RED_N-1:0] prod;
		sym_t r;
		prod = '0;
		r = '0;
		for (int i = 0; i < SYM_W; i++) begin
			if (b[i]) prod ^= RED_N'(a) << i;
		end
		for (int s = 0; s < RED_N; s++) begin
			if (prod[s]) r ^= red[s];
		end
		return r;
	endfunction
endpackage

FILE: hdl/rsce_if.sv
// channel interfaces: data item input, result output, register writes
// depends on rsce_pkg
`timescale 1ns / 1ps
interface rsce_in_if;
	import rsce_pkg::*;
	logic valid;
	logic ready;
	sym_t data_symbol;
	logic last_symbol;
	modport source(output valid, data_symbol, last_symbol, input ready);
	modport sink(input valid, data_symbol, last_symbol, output ready);
endinterface

interface rsce_out_if;
	import rsce_pkg::*;
	logic valid;
	logic ready;
	sym_t out_symbol;
	logic is_check;
	logic last_out;
	logic range_error;
	modport source(output valid, out_symbol, is_check, last_out, range_error, input ready);
	modport sink(input valid, out_symbol, is_check, last_out, range_error, output ready);
endinterface

interface rsce_cfg_if;
	import rsce_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

FILE: hdl/rsce_ctrl.sv
// sequencer: table and generator build, item intake, check symbol emission
// depends on rsce_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "reed_solomon_check_encoder_top_assert.svh"
module rsce_ctrl #(
	parameter int MAX_CHECK = rsce_pkg::MAX_CHECK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                last_symbol,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  rsce_pkg::rsce_sts_t sts,
	output rsce_pkg::rsce_cmd_t cmd
);
	import rsce_pkg::*;

	localparam int CNT_MAX = (MAX_CHECK > RED_N) ? MAX_CHECK : RED_N;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);

	typedef enum logic [3:0] {
		S_RED   = 4'b0001,
		S_GEN   = 4'b0010,
		S_RUN   = 4'b0100,
		S_CHECK = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, nc_cnt;
	logic out_valid_q;
	logic out_free;
	logic last_hit;

	assign nc_cnt    = CNT_W'(sts.nc_eff);
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_RUN) && out_free && !sts.cfg_wr;
	assign out_valid = out_valid_q;
	assign last_hit  = (CNT_W'(cnt_q + CNT_W'(1)) == nc_cnt);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		unique case (state_q)
			S_RED: begin
				cmd.red_step = 1'b1;
				cmd.red_idx = RED_W'(cnt_q);
				if (cnt_q == CNT_W'(RED_N - 2)) begin
					cmd.gen_init = 1'b1;
					state_d = S_GEN;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_GEN: begin
				if (cnt_q == nc_cnt) begin
					state_d = S_RUN;
					cnt_d = '0;
				end else begin
					cmd.gen_step = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_RUN: begin
				if (in_valid && in_ready) begin
					cmd.take = 1'b1;
					if (last_symbol && (sts.nc_eff != '0)) begin
						state_d = S_CHECK;
						cnt_d = '0;
					end
				end
			end
			S_CHECK: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_last = last_hit;
					if (last_hit) begin
						state_d = S_RUN;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = S_RED;
				cnt_d = '0;
			end
		endcase
		if (sts.cfg_wr) begin
			state_d = S_RED;
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RED;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.take || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`RSCE_ASSERT_NEXT(a_cfg_restart, clk, arst_n, sts.cfg_wr, state_q == S_RED, "register write did not restart the build")
	`RSCE_ASSERT_NEXT(a_last_to_check, clk, arst_n, cmd.take && last_symbol && (sts.nc_eff != '0), state_q == S_CHECK, "last item did not start check emission")
	`RSCE_ASSERT_IMPL(a_check_bound, clk, arst_n, state_q == S_CHECK, cnt_q < nc_cnt, "check counter ran past the check count")
	`RSCE_ASSERT_IMPL(a_red_bound, clk, arst_n, state_q == S_RED, cnt_q <= CNT_W'(RED_N - 2), "table build counter out of range")
	`RSCE_ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready, !cmd.take && !cmd.emit, "pending result overwritten")
endmodule

FILE: hdl/rsce_dp.sv
// datapath: configuration registers, reduction table, generator, parity lfsr,
// shared gf multiplier lanes and the result register; depends on rsce_pkg
`timescale 1ns / 1ps
module rsce_dp #(
	parameter int MAX_CHECK = rsce_pkg::MAX_CHECK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsce_pkg::rsce_cmd_t               cmd,
	output rsce_pkg::rsce_sts_t               sts,
	input  logic                              cfg_valid,
	input  logic [rsce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                              cfg_ready,
	input  rsce_pkg::sym_t                    data_symbol,
	input  logic                              last_symbol,
	output rsce_pkg::sym_t                    out_symbol,
	output logic                              is_check,
	output logic                              last_out,
	output logic                              range_error
);
	import rsce_pkg::*;

	logic [FB_W-1:0]   field_bits_q;
	logic [POLY_W-1:0] field_poly_q;
	logic [NC_W-1:0]   check_count_q;

	logic [M_W-1:0]  m_eff;
	sym_t            mask, msb, poly_m;
	logic            gen_err, cfg_known;
	logic [NC_W-1:0] nc;
	logic [NCX_W-1:0] nc_x;

	logic [RED_N-1:1][SYM_W-1:0] red_q;
	red_tab_t red_tab;

	sym_t h_q [MAX_CHECK];
	sym_t parity_q [MAX_CHECK];
	sym_t root_q, root_n, k, d;
	sym_t a_op [MAX_CHECK];
	sym_t b_op [MAX_CHECK];
	sym_t gm [MAX_CHECK];
	sym_t h_up [MAX_CHECK];
	sym_t p_up [MAX_CHECK];
	sym_t p_sh [MAX_CHECK];

	sym_t out_symbol_q;
	logic is_check_q, last_out_q, range_error_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (cfg_index)
			REG_FIELD_BITS, REG_FIELD_POLY, REG_CHECK_COUNT: cfg_known = 1'b1;
			default: cfg_known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_bits_q <= FB_RST;
			field_poly_q <= POLY_RST;
			check_count_q <= NC_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIELD_BITS:  field_bits_q <= cfg_wdata[FB_W-1:0];
				REG_FIELD_POLY:  field_poly_q <= cfg_wdata[POLY_W-1:0];
				REG_CHECK_COUNT: check_count_q <= cfg_wdata[NC_W-1:0];
				default: ;
			endcase
		end
	end

	// field width saturated to 3..SYM_W
	assign m_eff = (field_bits_q < FB_W'(3)) ? M_W'(3) :
		(M_W'(field_bits_q) > M_W'(SYM_W)) ? M_W'(SYM_W) : M_W'(field_bits_q);
	assign mask = ~(sym_t'('1) << m_eff);
	assign msb = sym_t'(1) << (m_eff - M_W'(1));
	assign poly_m = sym_t'(field_poly_q) & mask;
	assign gen_err = (NCX_W'(check_count_q) > NCX_W'(MAX_CHECK)) ||
		(POLY_W'(check_count_q) >= (POLY_W'(1) << m_eff));
	assign nc = gen_err ? '0 : check_count_q;
	assign nc_x = NCX_W'(nc);

	assign sts.cfg_wr = cfg_valid && cfg_ready && cfg_known;
	assign sts.nc_eff = nc;

	assign red_tab = {red_q, sym_t'(1)};
	assign root_n = gf_mulx(root_q, msb, poly_m, mask);
	assign d = data_symbol & mask;
	assign k = (parity_q[0] ^ data_symbol) & mask;

	for (genvar t = 0; t < MAX_CHECK; t++) begin : g_lane
		assign a_op[t] = cmd.gen_step ? h_q[t] : k;
		assign b_op[t] = cmd.gen_step ? root_n : h_q[t];
		assign gm[t] = gf_mul(a_op[t], b_op[t], red_tab);
		if (t < MAX_CHECK - 1) begin : g_up
			assign h_up[t] = h_q[t+1];
			assign p_sh[t] = parity_q[t+1];
			assign p_up[t] = (NCX_W'(t) + NCX_W'(2) <= nc_x) ? parity_q[t+1] : '0;
		end else begin : g_top
			assign h_up[t] = '0;
			assign p_sh[t] = '0;
			assign p_up[t] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.red_step) begin
			red_q[RED_W'(cmd.red_idx + RED_W'(1))] <=
				gf_mulx(red_tab[cmd.red_idx], msb, poly_m, mask);
		end
	end

	// generator kept reversed so that lane j holds the coefficient of parity j
	always_ff @(posedge clk) begin
		if (cmd.gen_init) begin
			root_q <= sym_t'(1);
			for (int t = 0; t < MAX_CHECK; t++) begin
				h_q[t] <= (NCX_W'(t) + NCX_W'(1) == nc_x) ? sym_t'(1) : '0;
			end
		end else if (cmd.gen_step) begin
			root_q <= root_n;
			for (int t = 0; t < MAX_CHECK; t++) begin
				h_q[t] <= h_up[t] ^ gm[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_CHECK; j++) begin
				parity_q[j] <= '0;
			end
		end else if (cmd.take) begin
			if (last_symbol && (nc == '0)) begin
				for (int j = 0; j < MAX_CHECK; j++) begin
					parity_q[j] <= '0;
				end
			end else if (nc != '0) begin
				for (int j = 0; j < MAX_CHECK; j++) begin
					if (NCX_W'(j) < nc_x) parity_q[j] <= (gm[j] ^ p_up[j]) & mask;
				end
			end
		end else if (cmd.emit) begin
			for (int j = 0; j < MAX_CHECK; j++) begin
				parity_q[j] <= cmd.emit_last ? '0 : p_sh[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			out_symbol_q <= d;
			is_check_q <= 1'b0;
			last_out_q <= last_symbol && (nc == '0);
			range_error_q <= gen_err;
		end else if (cmd.emit) begin
			out_symbol_q <= parity_q[0] & mask;
			is_check_q <= 1'b1;
			last_out_q <= cmd.emit_last;
			range_error_q <= 1'b0;
		end
	end

	assign out_symbol = out_symbol_q;
	assign is_check = is_check_q;
	assign last_out = last_out_q;
	assign range_error = range_error_q;
endmodule

FILE: hdl/reed_solomon_check_encoder_top.sv
// top level of the systematic reed-solomon check symbol encoder over gf(2^m)
// depends on rsce_pkg, rsce_if, rsce_ctrl and rsce_dp
// channels: data takes data symbols with a last mark, result gives the echoed
//   symbol and, after a last item, the check symbols, cfg writes field_bits
//   (index 0), field_poly (index 1) and check_count (index 2)
// every data item gives one echo, registered, in the cycle after it is taken; one
//   item a cycle is taken while results drain, set by the parallel gf multiplier lanes
// a last item is followed by check_count check symbols, one a cycle while results
//   drain, during which no item is taken
// after reset and after each write to index 0, 1 or 2 the block builds its reduction
//   table and then its generator, with data ready low
// a stalled receiver holds the result register; the next item is taken in the
//   cycle the held result leaves
// if check_count does not fit the field or exceeds MAX_CHECK every echo carries
//   range_error and no check symbols follow
`timescale 1ns / 1ps
module reed_solomon_check_encoder_top #(
	parameter int MAX_CHECK = rsce_pkg::MAX_CHECK_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rsce_in_if.sink    data,
	rsce_out_if.source result,
	rsce_cfg_if.sink   cfg
);
	import rsce_pkg::*;

	rsce_cmd_t cmd;
	rsce_sts_t sts;

	rsce_ctrl #(
		.MAX_CHECK(MAX_CHECK)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(data.valid),
		.last_symbol(data.last_symbol),
		.in_ready(data.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.sts(sts),
		.cmd(cmd)
	);

	rsce_dp #(
		.MAX_CHECK(MAX_CHECK)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_valid(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_wdata(cfg.wdata),
		.cfg_ready(cfg.ready),
		.data_symbol(data.data_symbol),
		.last_symbol(data.last_symbol),
		.out_symbol(result.out_symbol),
		.is_check(result.is_check),
		.last_out(result.last_out),
		.range_error(result.range_error)
	);
endmodule

FILE: test/rsce_encoder_checker.sv
// result checker for the reed-solomon check encoder: watches the data, result and
// register write channels, predicts every result and compares it field by field
// depends on rsce_pkg and rsce_if
`timescale 1ns / 1ps
module rsce_encoder_checker (
	input  logic clk,
	input  logic arst_n,
	rsce_in_if   data_mon,
	rsce_out_if  result_mon,
	rsce_cfg_if  cfg_mon,
	output int   pending,
	output int   fail_count,
	output int   results_seen
);
	import rsce_pkg::*;

	localparam int CHECK_DEPTH = MAX_CHECK_DEF;

	typedef struct packed {
		sym_t out_symbol;
		logic is_check;
		logic last_out;
		logic range_error;
	} rs_result_t;

	logic [FB_W-1:0]   cfg_bits;
	logic [POLY_W-1:0] cfg_poly;
	logic [NC_W-1:0]   cfg_nc;
	sym_t              gen_coeff [0:CHECK_DEPTH];
	sym_t              lfsr [0:CHECK_DEPTH-1];
	logic              gen_bad;
	rs_result_t        expected_q [$];
	int                errors = 0;
	int                seen = 0;

	function automatic int unsigned width_now();
		int unsigned m;
		m = 32'(cfg_bits);
		if (m < 3) m = 3;
		if (m > SYM_W) m = SYM_W;
		return m;
	endfunction

	function automatic sym_t width_mask(int unsigned m);
		return sym_t'((1 << m) - 1);
	endfunction

	// shift-and-add product, reduced by the configured polynomial
	function automatic sym_t field_product(sym_t a_in, sym_t b_in, int unsigned m);
		logic [POLY_W-1:0] a;
		sym_t b;
		sym_t r;
		sym_t mask;
		mask = width_mask(m);
		a = POLY_W'(a_in & mask);
		b = b_in & mask;
		r = '0;
		for (int i = 0; i < m; i++) begin
			if (b[0]) r ^= a[SYM_W-1:0];
			b = b >> 1;
			a = a << 1;
			if (a[m]) a ^= cfg_poly;
			a &= POLY_W'(mask);
		end
		return r & mask;
	endfunction

	// generator with roots alpha^1 .. alpha^nc
	task automatic rebuild_generator();
		int unsigned m;
		sym_t root;
		m = width_now();
		for (int i = 0; i <= CHECK_DEPTH; i++) gen_coeff[i] = '0;
		gen_bad = (int'(cfg_nc) > CHECK_DEPTH) || (int'(cfg_nc) >= (1 << m));
		if (!gen_bad) begin
			gen_coeff[0] = sym_t'(1);
			root = sym_t'(1);
			for (int i = 1; i <= int'(cfg_nc); i++) begin
				root = field_product(root, sym_t'(2), m);
				gen_coeff[i] = gen_coeff[i-1];
				for (int j = i - 1; j > 0; j--)
					gen_coeff[j] = gen_coeff[j-1] ^ field_product(gen_coeff[j], root, m);
				gen_coeff[0] = field_product(gen_coeff[0], root, m);
			end
		end
	endtask

	task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_FIELD_BITS: begin
				cfg_bits = value[FB_W-1:0];
				rebuild_generator();
			end
			REG_FIELD_POLY: begin
				cfg_poly = value[POLY_W-1:0];
				rebuild_generator();
			end
			REG_CHECK_COUNT: begin
				cfg_nc = value[NC_W-1:0];
				rebuild_generator();
			end
			default: ;
		endcase
	endtask

	task automatic encode_symbol(sym_t din, logic fin);
		int unsigned m;
		int unsigned nc;
		sym_t mask;
		sym_t d;
		sym_t k;
		sym_t p;
		rs_result_t r;
		m = width_now();
		mask = width_mask(m);
		d = din & mask;
		nc = gen_bad ? 0 : 32'(cfg_nc);
		if (nc > 0) begin
			k = (lfsr[0] ^ d) & mask;
			for (int j = 0; j < nc; j++) begin
				p = field_product(k, gen_coeff[nc-1-j], m);
				if (j + 1 < nc) p ^= lfsr[j+1];
				lfsr[j] = p & mask;
			end
		end
		r.out_symbol = d;
		r.is_check = 1'b0;
		r.last_out = fin && (nc == 0);
		r.range_error = gen_bad;
		expected_q = {expected_q, r};
		if (fin) begin
			for (int j = 0; j < nc; j++) begin
				r.out_symbol = lfsr[j] & mask;
				r.is_check = 1'b1;
				r.last_out = (j + 1 == nc);
				r.range_error = 1'b0;
				expected_q = {expected_q, r};
			end
			for (int j = 0; j < CHECK_DEPTH; j++) lfsr[j] = '0;
		end
	endtask

	task automatic check_result();
		rs_result_t got;
		rs_result_t want;
		got.out_symbol = result_mon.out_symbol;
		got.is_check = result_mon.is_check;
		got.last_out = result_mon.last_out;
		got.range_error = result_mon.range_error;
		seen++;
		if (expected_q.size() == 0) begin
			if (errors < 10)
				$display("unexpected result: sym %03h chk %0b last %0b err %0b",
					got.out_symbol, got.is_check, got.last_out, got.range_error);
			errors++;
		end else begin
			want = expected_q.pop_front();
			if (got.out_symbol !== want.out_symbol || got.is_check !== want.is_check ||
					got.last_out !== want.last_out || got.range_error !== want.range_error) begin
				if (errors < 10)
					$display("mismatch: expected sym %03h chk %0b last %0b err %0b, got sym %03h chk %0b last %0b err %0b",
						want.out_symbol, want.is_check, want.last_out, want.range_error,
						got.out_symbol, got.is_check, got.last_out, got.range_error);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bits = FB_RST;
			cfg_poly = POLY_RST;
			cfg_nc = NC_RST;
			for (int j = 0; j < CHECK_DEPTH; j++) lfsr[j] = '0;
			rebuild_generator();
			expected_q.delete();
			pending <= 0;
			fail_count <= errors;
			results_seen <= seen;
		end else begin
			if (result_mon.valid && result_mon.ready) check_result();
			if (cfg_mon.valid && cfg_mon.ready) apply_write(cfg_mon.index, cfg_mon.wdata);
			if (data_mon.valid && data_mon.ready)
				encode_symbol(data_mon.data_symbol, data_mon.last_symbol);
			pending <= expected_q.size();
			fail_count <= errors;
			results_seen <= seen;
		end
	end
endmodule

FILE: test/reed_solomon_check_encoder_top_tb.sv
// testbench top for the reed-solomon check encoder: clock, reset, directed and
// random stimulus over several field settings, receiver stalls and the verdict
// depends on rsce_pkg, rsce_if, rsce_encoder_checker and the encoder top level
`timescale 1ns / 1ps
module reed_solomon_check_encoder_top_tb;
	import rsce_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 54;

	logic clk = 1'b0;
	logic arst_n;
	int   pending;
	int   fail_count;
	int   results_seen;
	int   send_idle = 0;
	int   recv_stall = 0;
	int   hold_req_seq = 0;
	int   items_sent = 0;
	int   writes_done = 0;

	rsce_in_if  data_ch ();
	rsce_out_if result_ch ();
	rsce_cfg_if cfg_ch ();

	reed_solomon_check_encoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	rsce_encoder_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_mon     (data_ch),
		.result_mon   (result_ch),
		.cfg_mon      (cfg_ch),
		.pending      (pending),
		.fail_count   (fail_count),
		.results_seen (results_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("reed_solomon_check_encoder_top test failed");
		$finish;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req_seq) begin
				hold_seen = hold_req_seq;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	function automatic logic [POLY_W-1:0] primitive_poly(int m);
		case (m)
			3:  return POLY_W'(11);
			4:  return POLY_W'(19);
			5:  return POLY_W'(37);
			6:  return POLY_W'(67);
			7:  return POLY_W'(137);
			8:  return POLY_W'(285);
			9:  return POLY_W'(529);
			10: return POLY_W'(1033);
			11: return POLY_W'(2053);
			default: return POLY_W'(4179);
		endcase
	endfunction

	task automatic send_item(sym_t sym, logic fin);
		while ($urandom_range(0, 99) < send_idle) begin
			data_ch.valid <= 1'b0;
			@(posedge clk);
		end
		data_ch.valid <= 1'b1;
		data_ch.data_symbol <= sym;
		data_ch.last_symbol <= fin;
		@(posedge clk);
		while (!data_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering items and wait for every expected result
	task automatic drain();
		data_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		writes_done++;
	endtask

	task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		drain();
		write_reg(idx, value);
		cfg_ch.valid <= 1'b0;
	endtask

	// unused upper bits of the narrow registers carry random noise
	task automatic configure(logic [FB_W-1:0] bits, logic [POLY_W-1:0] poly,
			logic [NC_W-1:0] nc);
		drain();
		write_reg(REG_FIELD_BITS, CFG_DATA_W'({$urandom, bits}));
		write_reg(REG_FIELD_POLY, poly);
		write_reg(REG_CHECK_COUNT, CFG_DATA_W'({$urandom, nc}));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [FB_W-1:0]   bits;
		logic [POLY_W-1:0] poly;
		logic [NC_W-1:0]   nc;
		int m;
		int cap;
		if ($urandom_range(0, 9) == 0) bits = FB_W'($urandom_range(0, 15));
		else bits = FB_W'($urandom_range(3, 12));
		m = (bits < 3) ? 3 : (bits > 12) ? 12 : int'(bits);
		poly = ($urandom_range(0, 5) == 0) ? POLY_W'($urandom) : primitive_poly(m);
		cap = (1 << m) - 1;
		if (cap > MAX_CHECK_DEF) cap = MAX_CHECK_DEF;
		case ($urandom_range(0, 9))
			0: nc = '0;
			1: nc = NC_W'($urandom_range(0, 63));
			2: nc = NC_W'(cap);
			default: nc = NC_W'($urandom_range(1, (cap > 8) ? 8 : cap));
		endcase
		configure(bits, poly, nc);
	endtask

	initial begin
		int phase_items;
		int len;
		int cut;
		arst_n <= 1'b0;
		data_ch.valid <= 1'b0;
		data_ch.data_symbol <= '0;
		data_ch.last_symbol <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_FIELD_BITS;
		cfg_ch.wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, symbol extremes and masking of upper bits
		send_item(sym_t'(0), 1'b0);
		send_item(sym_t'(12'hfff), 1'b0);
		send_item(sym_t'(63), 1'b1);
		// widest field with the most check symbols
		configure(4'd12, primitive_poly(12), 6'd32);
		send_item(sym_t'(12'hfff), 1'b0);
		send_item(sym_t'(0), 1'b0);
		send_item(sym_t'(12'haaa), 1'b1);
		// narrowest field, largest count that fits
		configure(4'd3, primitive_poly(3), 6'd7);
		send_item(sym_t'(7), 1'b0);
		send_item(sym_t'(5), 1'b1);
		// count does not fit the field
		configure(4'd3, primitive_poly(3), 6'd8);
		send_item(sym_t'(3), 1'b0);
		send_item(sym_t'(6), 1'b1);
		// count above the check depth
		configure(4'd12, primitive_poly(12), 6'd33);
		send_item(sym_t'(1), 1'b1);
		// field widths saturated at both ends
		configure(4'd0, primitive_poly(3), 6'd2);
		send_item(sym_t'(2), 1'b0);
		send_item(sym_t'(4), 1'b1);
		configure(4'd15, primitive_poly(12), 6'd3);
		send_item(sym_t'(12'h800), 1'b1);
		// zero check symbols: echo only
		configure(4'd8, primitive_poly(8), 6'd0);
		send_item(sym_t'(10), 1'b0);
		send_item(sym_t'(255), 1'b1);
		// write to the unused index changes nothing
		write_one(REG_SPARE, CFG_DATA_W'($urandom));
		send_item(sym_t'(1), 1'b1);
		// register write in the middle of a block
		configure(4'd8, primitive_poly(8), 6'd4);
		send_item(sym_t'(17), 1'b0);
		send_item(sym_t'(34), 1'b0);
		write_one(REG_CHECK_COUNT, CFG_DATA_W'(6));
		send_item(sym_t'(51), 1'b0);
		send_item(sym_t'(68), 1'b1);
		send_item(sym_t'(200), 1'b1);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall <= 0;  end
				1: begin send_idle = 59; recv_stall <= 0;  end
				2: begin send_idle = 0;  recv_stall <= 59; end
				3: begin send_idle = 31; recv_stall <= 31; end
				default: begin send_idle = 0; recv_stall <= 0; end
			endcase
			phase_items = 0;
			random_config();
			if (ph == 4) hold_req_seq <= hold_req_seq + 1;
			while (phase_items < PHASE_ITEMS) begin
				len = (ph == 4 && phase_items == 0) ? 20 : $urandom_range(1, 8);
				cut = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
				for (int i = 0; i < len; i++) begin
					if (cut != 0 && i == cut)
						write_one(REG_CHECK_COUNT, CFG_DATA_W'($urandom_range(0, 12)));
					send_item(sym_t'($urandom), i == len - 1);
				end
				phase_items += len;
				if ($urandom_range(0, 2) == 0) random_config();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("summary: %0d data items, %0d results checked, %0d register writes",
			items_sent, results_seen, writes_done);
		$display("covered widths 3 to 12 with saturation, zero and over-range check counts, mid-block writes, long hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("reed_solomon_check_encoder_top test passed");
		end else begin
			$display("reed_solomon_check_encoder_top test failed");
		end
		$finish;
	end
endmodule
